>>> src/bdlp_pkg.sv
package bdlp_pkg;

  // configuration register width and index width
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS   = 1'b0,
    REG_LONG_PRESS_TICKS = 1'b1
  } cfg_reg_t;

  // register values after reset
  localparam logic [REG_W-1:0] DEBOUNCE_TICKS_RST   = 16'd100;
  localparam logic [REG_W-1:0] LONG_PRESS_TICKS_RST = 16'd1000;

  // status of the event queue seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> src/button_debounce_long_press_top.sv
// Debounced button front end with long-press detection.
// Input channel: one transaction per millisecond tick, in_tdata carries the raw
// level of every button (bit i is button i, 1 is pressed).
// Output channel: one transaction per event: button index and new stable level
// in out_tdata, out_tuser high for a long-press expiry, out_tlast high on the
// final event caused by a tick. A tick may cause no event at all.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr (0 debounce
// ticks, 1 long-press ticks) at the clock edge; write only while idle.
// A tick's first event passes the event queue, the pending-event and output
// registers; later events follow one per cycle while out_tready is high.
// Throughput: one tick per cycle while each tick causes at most one event; the
// output serializer sends one event per cycle and a two-tick event queue
// decouples it from the tick lanes, so in_tready drops while that queue is full.
// Reset: registers return to 100 and 1000, every button is released with the
// rising edge armed and no countdown running; the queue is emptied.
// A stall on out_tready holds the current event and fills the queue, then
// stalls the input.
module button_debounce_long_press_top #(
  parameter int  NUM_BUTTONS = 3,
  parameter int  COUNT_WIDTH = 16,
  localparam int IN_W  = ((NUM_BUTTONS + 7) / 8) * 8,
  localparam int BW    = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1,
  localparam int OUT_W = ((BW + 1 + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [bdlp_pkg::REG_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,   // levels
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,  // button, pressed
  output logic                           out_tuser,  // long_press
  output logic                           out_tlast
);
  import bdlp_pkg::*;

  localparam int QW = 4 * NUM_BUTTONS;

  q_stat_t                  q_stat;
  logic                     push, pop;
  logic [2*NUM_BUTTONS-1:0] ev_valid, ev_press;
  logic [QW-1:0]            q_rdata;
  logic [BW-1:0]            out_button;
  logic                     out_pressed;

  bdlp_front #(.NB(NUM_BUTTONS), .CW(COUNT_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .levels   (in_tdata[NUM_BUTTONS-1:0]),
    .q_stat   (q_stat),
    .push     (push),
    .ev_valid (ev_valid),
    .ev_press (ev_press)
  );

  bdlp_queue #(.W(QW), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({ev_press, ev_valid}),
    .pop   (pop),
    .rdata (q_rdata),
    .q_stat(q_stat)
  );

  bdlp_back #(.NB(NUM_BUTTONS), .BW(BW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_valid    (q_rdata[2*NUM_BUTTONS-1:0]),
    .q_press    (q_rdata[QW-1:2*NUM_BUTTONS]),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_button (out_button),
    .out_pressed(out_pressed),
    .out_long   (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = OUT_W'({out_pressed, out_button});

endmodule

>>> src/bdlp_front.sv
module bdlp_front #(
  parameter int NB = 3,
  parameter int CW = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [bdlp_pkg::REG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [NB-1:0]                 levels,
  input  bdlp_pkg::q_stat_t             q_stat,
  output logic                          push,
  output logic [2*NB-1:0]               ev_valid,
  output logic [2*NB-1:0]               ev_press
);
  import bdlp_pkg::*;

  // register value masked to counter width, zero loads as one
  function automatic logic [CW-1:0] to_load(input logic [REG_W-1:0] v);
    logic [CW-1:0] m;
    m = CW'(v);
    return (m == '0) ? CW'(1) : m;
  endfunction

  logic [CW-1:0] db_load_r, lp_load_r;

  logic [NB-1:0] stable_r, stable_nxt;
  logic [NB-1:0] prev_r, prev_nxt;
  logic [NB-1:0] armed_r, armed_nxt;
  logic [NB-1:0] dba_r, dba_nxt;
  logic [NB-1:0] rc_r, rc_nxt;
  logic [NB-1:0] la_r, la_nxt;
  logic [CW-1:0] dbc_r [NB];
  logic [CW-1:0] dbc_nxt [NB];
  logic [CW-1:0] lc_r [NB];
  logic [CW-1:0] lc_nxt [NB];

  logic [NB-1:0] edge_hit;
  logic [NB-1:0] do_eval;
  logic [CW-1:0] lc_dec [NB];
  logic [CW-1:0] dbc_dec [NB];
  logic          accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (|ev_valid);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_load_r <= to_load(DEBOUNCE_TICKS_RST);
      lp_load_r <= to_load(LONG_PRESS_TICKS_RST);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DEBOUNCE_TICKS:   db_load_r <= to_load(cfg_wdata);
        REG_LONG_PRESS_TICKS: lp_load_r <= to_load(cfg_wdata);
        default: ;
      endcase
    end
  end

  // per-button lanes, all evaluated in parallel for one tick
  always_comb begin
    stable_nxt = stable_r;
    prev_nxt   = levels;
    armed_nxt  = armed_r;
    dba_nxt    = dba_r;
    rc_nxt     = rc_r;
    la_nxt     = la_r;
    ev_valid   = '0;
    ev_press   = '0;
    edge_hit   = '0;
    do_eval    = '0;
    for (int i = 0; i < NB; i++) begin
      dbc_nxt[i] = dbc_r[i];
      lc_nxt[i]  = lc_r[i];
      lc_dec[i]  = lc_r[i] - CW'(1);
      dbc_dec[i] = dbc_r[i] - CW'(1);

      // armed edge restarts the debounce countdown
      edge_hit[i] = armed_r[i] ? (prev_r[i] && !levels[i]) : (!prev_r[i] && levels[i]);
      if (edge_hit[i]) begin
        dba_nxt[i] = 1'b1;
        dbc_nxt[i] = db_load_r;
        rc_nxt[i]  = 1'b0;
      end

      // long-press countdown
      if (la_r[i]) begin
        lc_nxt[i] = lc_dec[i];
        if (lc_dec[i] == '0) begin
          la_nxt[i]       = 1'b0;
          ev_valid[2*i]   = 1'b1;
          ev_press[2*i]   = stable_r[i];
        end
      end

      // recheck or debounce expiry
      if (rc_nxt[i]) begin
        rc_nxt[i]  = 1'b0;
        do_eval[i] = 1'b1;
      end else if (dba_r[i] && !edge_hit[i]) begin
        dbc_nxt[i] = dbc_dec[i];
        if (dbc_dec[i] == '0) begin
          dba_nxt[i] = 1'b0;
          do_eval[i] = 1'b1;
        end
      end

      // sample level against stable state, state toggles in every case
      if (do_eval[i]) begin
        if (!stable_r[i] && levels[i]) begin
          la_nxt[i]    = 1'b1;
          lc_nxt[i]    = lp_load_r;
          armed_nxt[i] = 1'b1;
        end else if (stable_r[i] && !levels[i]) begin
          la_nxt[i]    = 1'b0;
          armed_nxt[i] = 1'b0;
        end else begin
          rc_nxt[i] = 1'b1;
        end
        stable_nxt[i]   = !stable_r[i];
        ev_valid[2*i+1] = 1'b1;
        ev_press[2*i+1] = !stable_r[i];
      end
    end
  end

  // button state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '0;
      prev_r   <= '0;
      armed_r  <= '0;
      dba_r    <= '0;
      rc_r     <= '0;
      la_r     <= '0;
      for (int i = 0; i < NB; i++) begin
        dbc_r[i] <= '0;
        lc_r[i]  <= '0;
      end
    end else if (accept) begin
      stable_r <= stable_nxt;
      prev_r   <= prev_nxt;
      armed_r  <= armed_nxt;
      dba_r    <= dba_nxt;
      rc_r     <= rc_nxt;
      la_r     <= la_nxt;
      for (int i = 0; i < NB; i++) begin
        dbc_r[i] <= dbc_nxt[i];
        lc_r[i]  <= lc_nxt[i];
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a pending recheck never coexists with a running debounce countdown
  a_rc_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (rc_r & dba_r) == '0)
    else $error("recheck pending while debounce countdown active");
`endif

endmodule

>>> src/bdlp_queue.sv
module bdlp_queue #(
  parameter int W     = 6,
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [W-1:0]      wdata,
  input  logic              pop,
  output logic [W-1:0]      rdata,
  output bdlp_pkg::q_stat_t q_stat
);
  import bdlp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  assign rdata        = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNTW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (push && !pop)
        cnt_r <= cnt_r + CNTW'(1);
      else if (pop && !push)
        cnt_r <= cnt_r - CNTW'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push)
      mem_r[wr_ptr_r] <= wdata;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("event queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("event queue underflow");
`endif

endmodule

>>> src/bdlp_back.sv
module bdlp_back #(
  parameter int NB = 3,
  parameter int BW = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bdlp_pkg::q_stat_t q_stat,
  input  logic [2*NB-1:0]   q_valid,
  input  logic [2*NB-1:0]   q_press,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BW-1:0]     out_button,
  output logic              out_pressed,
  output logic              out_long,
  output logic              out_tlast
);
  import bdlp_pkg::*;

  localparam int S  = 2 * NB;
  localparam int SW = $clog2(S);

  logic [S-1:0]  rem_r, rem_nxt;
  logic [S-1:0]  pr_r, pr_nxt;
  logic          ov_r, ov_nxt;
  logic [BW-1:0] btn_r, btn_nxt;
  logic          press_r, press_nxt;
  logic          long_r, long_nxt;
  logic          last_r, last_nxt;
  logic          emit;

  logic [S-1:0]  low;
  logic [S-1:0]  rest;
  logic [SW-1:0] sel;
  logic          adv;

  // lowest pending event slot: ascending button, long before debounce per button
  assign low  = rem_r & (~rem_r + S'(1));
  assign rest = rem_r & ~low;
  assign adv  = !ov_r || out_tready;

  always_comb begin
    sel = '0;
    for (int j = 0; j < S; j++) begin
      if (low[j])
        sel = SW'(j);
    end
  end

  // step through events of one tick, reload from the queue as it drains
  always_comb begin
    rem_nxt   = rem_r;
    pr_nxt    = pr_r;
    ov_nxt    = ov_r && !out_tready;
    btn_nxt   = btn_r;
    press_nxt = press_r;
    long_nxt  = long_r;
    last_nxt  = last_r;
    emit      = adv && (rem_r != '0);
    pop       = 1'b0;
    if (emit) begin
      ov_nxt    = 1'b1;
      btn_nxt   = BW'(sel >> 1);
      press_nxt = pr_r[sel];
      long_nxt  = !sel[0];
      last_nxt  = (rest == '0);
      rem_nxt   = rest;
    end
    if (!q_stat.empty && ((rem_r == '0) || (emit && rest == '0))) begin
      pop     = 1'b1;
      rem_nxt = q_valid;
      pr_nxt  = q_press;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // output payload and press levels of the tick in progress
  always_ff @(posedge clk) begin
    pr_r    <= pr_nxt;
    btn_r   <= btn_nxt;
    press_r <= press_nxt;
    long_r  <= long_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid  = ov_r;
  assign out_button  = btn_r;
  assign out_pressed = press_r;
  assign out_long    = long_r;
  assign out_tlast   = last_r;

`ifndef NO_ASSERTIONS
  // an event that is not the last of its tick leaves events behind it
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !last_r) |-> (rem_r != '0))
    else $error("non-final event with nothing left to send");
`endif

endmodule
